// File: hw/rtl/urs_pkg.sv
// ============================================================================
// Uplink reference sample package
// Shared types, constants and helper functions for the sample generator.
// ============================================================================
package urs_pkg;

    localparam int unsigned ROOT_MOD     = 30;
    localparam int unsigned ROOT_RECIP   = 34953;
    localparam int unsigned ROOT_SHIFT   = 20;
    localparam int unsigned TURN         = 768;
    localparam int unsigned HALF         = 384;
    localparam int unsigned QUARTER      = 192;
    localparam int unsigned AMP_BIAS     = 128;
    localparam int unsigned DMRS_LEN     = 12;
    localparam int unsigned DMRS_SHIFT   = 5;
    localparam int unsigned SLOT_STEP_LG = 6;
    localparam real         PI_VALUE     = 3.14159265358979323846;
    localparam real         AMP_SCALE    = 127.0;
    localparam real         PHASE_STEP   = PI_VALUE / real'(HALF);

    localparam logic MODE_DMRS = 1'b0;
    localparam logic MODE_SRS  = 1'b1;

    typedef enum logic [1:0] {
        BW_8  = 2'd0,
        BW_16 = 2'd1,
        BW_32 = 2'd2,
        BW_64 = 2'd3
    } bw_code_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] user_id;
        logic [7:0]  slot;
        logic [7:0]  bw_code;
        logic [8:0]  sample_index;
    } req_t;

    typedef struct packed {
        logic [7:0] in_phase;
        logic [7:0] quadrature;
        logic       last;
        logic       out_of_range;
    } rsp_t;

    typedef logic [QUARTER:0][6:0] amp_table_t;

    // Quarter-wave table: trunc(127 * cos(m * pi / 384)) for m = 0 .. 192.
    function automatic amp_table_t build_amp_table();
        amp_table_t tbl;
        real        ang;
        for (int i = 0; i <= int'(QUARTER); i++)
        begin
            ang    = PHASE_STEP * real'(i);
            tbl[i] = 7'($rtoi(AMP_SCALE * $cos(ang)));
        end
        return tbl;
    endfunction

    localparam amp_table_t QUARTER_AMP = build_amp_table();

    // Residue modulo three, using the fact that four is one modulo three.
    function automatic logic [1:0] mod3(input logic [15:0] x);
        logic [4:0] s1;
        logic [2:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int i = 0; i < 8; i++)
        begin
            s1 = s1 + 5'(x[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        s3 = 3'(s2[1:0]) + 3'(s2[2]);
        if (s3 >= 3'd3)
        begin
            s3 = s3 - 3'd3;
        end
        return s3[1:0];
    endfunction

    // 128 plus or minus the table value for a phase in units of pi/384.
    function automatic logic [7:0] amplitude(input logic [9:0] p);
        logic [7:0] idx;
        logic       neg;
        logic [6:0] a;
        if (p <= 10'(QUARTER))
        begin
            idx = p[7:0];
            neg = 1'b0;
        end
        else if (p < 10'(HALF))
        begin
            idx = 8'(10'(HALF) - p);
            neg = 1'b1;
        end
        else if (p <= 10'(HALF + QUARTER))
        begin
            idx = 8'(p - 10'(HALF));
            neg = 1'b1;
        end
        else
        begin
            idx = 8'(10'(TURN) - p);
            neg = 1'b0;
        end
        a = QUARTER_AMP[idx];
        return neg ? 8'(AMP_BIAS) - 8'(a) : 8'(AMP_BIAS) + 8'(a);
    endfunction

endpackage

// File: hw/rtl/urs_req_if.sv
// ============================================================================
// Sample request channel
// Valid/ready channel that carries one sample request per transaction.
// ============================================================================
interface urs_req_if;
    logic          valid;
    logic          ready;
    urs_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/urs_rsp_if.sv
// ============================================================================
// Sample result channel
// Valid/ready channel that carries one reference sample per transaction.
// ============================================================================
interface urs_rsp_if;
    logic          valid;
    logic          ready;
    urs_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/uplink_reference_sample_generator_core.sv
// The generator returns one chirp reference sample for every request
// transaction, with the root taken from the user identity. It accepts a
// request in every clock cycle while the result channel is not stalled, and
// delivers each result through a five-stage pipeline that ends in the output
// register. When the result channel stalls, the whole pipeline holds.
// ============================================================================
// Uplink reference sample generator core
// Pipelined chirp phase computation and quarter-wave amplitude lookup.
// ============================================================================
module uplink_reference_sample_generator_core
(
    input  logic          clk,
    input  logic          rst_n,
    urs_req_if.sink       req,
    urs_rsp_if.source     rsp
);

    logic pipe_en;

    logic        v1_reg;
    logic [11:0] quot_reg;
    logic [17:0] kk_reg;
    logic [15:0] user1_reg;
    logic        mode1_reg;
    logic [9:0]  base1_reg;
    logic [2:0]  shift1_reg;
    logic        oor1_reg;
    logic        last1_reg;

    logic        v2_reg;
    logic [4:0]  root_reg;
    logic [9:0]  kkm_reg;
    logic        mode2_reg;
    logic [9:0]  base2_reg;
    logic [2:0]  shift2_reg;
    logic        oor2_reg;
    logic        last2_reg;

    logic        v3_reg;
    logic [19:0] prod_reg;
    logic        mode3_reg;
    logic [9:0]  base3_reg;
    logic        oor3_reg;
    logic        last3_reg;

    logic        v4_reg;
    logic [9:0]  phase_reg;
    logic        mode4_reg;
    logic        oor4_reg;
    logic        last4_reg;

    logic          out_valid_reg;
    urs_pkg::rsp_t out_data_reg;

    logic [31:0] quot_prod;
    logic [9:0]  k_plus;
    logic [8:0]  len;
    logic [2:0]  shift;
    logic [9:0]  base;
    logic [16:0] quot_x30;
    logic [15:0] resid;
    logic [14:0] uk_prod;
    logic [9:0]  t_mod;
    logic [10:0] p_sum;
    logic [9:0]  p_next;
    logic [9:0]  q_phase;
    urs_pkg::rsp_t out_next;

    assign pipe_en   = !out_valid_reg || rsp.ready;
    assign req.ready = pipe_en;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        quot_prod = 32'(req.data.user_id) * 32'(urs_pkg::ROOT_RECIP);
        k_plus    = 10'(req.data.sample_index) + 10'd1;
        base      = {urs_pkg::mod3(16'(req.data.slot[7:2])), req.data.slot[1:0],
                     urs_pkg::SLOT_STEP_LG'(0)};
        if (req.data.mode == urs_pkg::MODE_DMRS)
        begin
            len   = 9'(urs_pkg::DMRS_LEN);
            shift = 3'(urs_pkg::DMRS_SHIFT);
        end
        else
        begin
            base = '0;
            case (req.data.bw_code)
                8'(urs_pkg::BW_16):
                begin
                    len   = 9'd96;
                    shift = 3'd2;
                end
                8'(urs_pkg::BW_32):
                begin
                    len   = 9'd192;
                    shift = 3'd1;
                end
                8'(urs_pkg::BW_64):
                begin
                    len   = 9'd384;
                    shift = 3'd0;
                end
                default:
                begin
                    len   = 9'd48;
                    shift = 3'd3;
                end
            endcase
        end
    end

    always_comb
    begin
        quot_x30 = 17'(quot_reg) * 17'(urs_pkg::ROOT_MOD);
        resid    = user1_reg - quot_x30[15:0];
        uk_prod  = 15'(root_reg) * 15'(kkm_reg);
        t_mod    = {urs_pkg::mod3(16'(prod_reg[19:8])), prod_reg[7:0]};
        p_sum    = 11'(base3_reg) + 11'(urs_pkg::TURN) - 11'(t_mod);
        if (p_sum >= 11'(urs_pkg::TURN))
        begin
            p_next = 10'(p_sum - 11'(urs_pkg::TURN));
        end
        else
        begin
            p_next = p_sum[9:0];
        end
        if (phase_reg >= 10'(urs_pkg::QUARTER))
        begin
            q_phase = phase_reg - 10'(urs_pkg::QUARTER);
        end
        else
        begin
            q_phase = phase_reg + 10'(urs_pkg::TURN - urs_pkg::QUARTER);
        end
        out_next.in_phase     = urs_pkg::amplitude(phase_reg);
        out_next.quadrature   = (mode4_reg == urs_pkg::MODE_DMRS) ?
                                urs_pkg::amplitude(q_phase) : 8'd0;
        out_next.last         = last4_reg;
        out_next.out_of_range = oor4_reg;
        if (oor4_reg)
        begin
            out_next.in_phase   = 8'd0;
            out_next.quadrature = 8'd0;
            out_next.last       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            v1_reg        <= req.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            quot_reg   <= quot_prod[urs_pkg::ROOT_SHIFT +: 12];
            kk_reg     <= 18'(19'(req.data.sample_index) * 19'(k_plus));
            user1_reg  <= req.data.user_id;
            mode1_reg  <= req.data.mode;
            base1_reg  <= base;
            shift1_reg <= shift;
            oor1_reg   <= req.data.sample_index >= len;
            last1_reg  <= req.data.sample_index == (len - 9'd1);

            root_reg   <= resid[4:0] + 5'd1;
            kkm_reg    <= {urs_pkg::mod3(16'(kk_reg[17:8])), kk_reg[7:0]};
            mode2_reg  <= mode1_reg;
            base2_reg  <= base1_reg;
            shift2_reg <= shift1_reg;
            oor2_reg   <= oor1_reg;
            last2_reg  <= last1_reg;

            prod_reg   <= 20'(uk_prod) << shift2_reg;
            mode3_reg  <= mode2_reg;
            base3_reg  <= base2_reg;
            oor3_reg   <= oor2_reg;
            last3_reg  <= last2_reg;

            phase_reg  <= p_next;
            mode4_reg  <= mode3_reg;
            oor4_reg   <= oor3_reg;
            last4_reg  <= last3_reg;

            out_data_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.out_of_range |->
            rsp.data.in_phase == 8'd0 && rsp.data.quadrature == 8'd0 && !rsp.data.last)
        else $error("out-of-range result carries nonzero fields");

    a_in_range_amp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.out_of_range |-> rsp.data.in_phase != 8'd0)
        else $error("in-range result has zero in-phase amplitude");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> v1_reg)
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |=> $stable(v4_reg) && $stable(phase_reg))
        else $error("pipeline advanced during an output stall");
`endif

endmodule
